>>> rtl/sveu_pkg.sv
// package: payload types, constants and opcodes of the scalar vector execute unit
`default_nettype none
package sveu_pkg;
  localparam int CONTEXTS_DEF = 4;
  localparam int VECTOR_REGS_DEF = 32;
  localparam int LANES_DEF = 8;
  localparam int SCALAR_REGS = 256;
  localparam logic [15:0] PC_LIMIT_RESET = 16'd1024;

  localparam logic [3:0] FLAG_Z = 4'b1000;
  localparam logic [3:0] FLAG_N = 4'b0100;
  localparam logic [3:0] FLAG_C = 4'b0010;
  localparam logic [3:0] FLAG_V = 4'b0001;

  localparam logic [7:0] OP_HALT = 8'h00;
  localparam logic [7:0] OP_ADD = 8'h01;
  localparam logic [7:0] OP_SUB = 8'h02;
  localparam logic [7:0] OP_MUL = 8'h03;
  localparam logic [7:0] OP_DIV = 8'h04;
  localparam logic [7:0] OP_MOV = 8'h07;
  localparam logic [7:0] OP_PRINT = 8'h08;
  localparam logic [7:0] OP_ADDI = 8'h09;
  localparam logic [7:0] OP_SUBI = 8'h0A;
  localparam logic [7:0] OP_MULI = 8'h0B;
  localparam logic [7:0] OP_DIVI = 8'h0C;
  localparam logic [7:0] OP_MOVI = 8'h0F;
  localparam logic [7:0] OP_BEQ = 8'h10;
  localparam logic [7:0] OP_BNE = 8'h11;
  localparam logic [7:0] OP_BCS = 8'h12;
  localparam logic [7:0] OP_BCC = 8'h13;
  localparam logic [7:0] OP_BMI = 8'h14;
  localparam logic [7:0] OP_BPL = 8'h15;
  localparam logic [7:0] OP_BVS = 8'h16;
  localparam logic [7:0] OP_BVC = 8'h17;
  localparam logic [7:0] OP_BHI = 8'h18;
  localparam logic [7:0] OP_BLS = 8'h19;
  localparam logic [7:0] OP_BGE = 8'h1A;
  localparam logic [7:0] OP_BLT = 8'h1B;
  localparam logic [7:0] OP_BGT = 8'h1C;
  localparam logic [7:0] OP_BLE = 8'h1D;
  localparam logic [7:0] OP_BAL = 8'h1E;
  localparam logic [7:0] OP_VVADD = 8'h21;
  localparam logic [7:0] OP_VVSUB = 8'h22;
  localparam logic [7:0] OP_VVMUL = 8'h23;
  localparam logic [7:0] OP_VIADD = 8'h29;
  localparam logic [7:0] OP_VISUB = 8'h2A;
  localparam logic [7:0] OP_VIMUL = 8'h2B;
  localparam logic [7:0] OP_VSADD = 8'h31;
  localparam logic [7:0] OP_VSSUB = 8'h32;
  localparam logic [7:0] OP_VSMUL = 8'h33;

  typedef struct packed {
    logic [1:0] context_req;
    logic [7:0] op_code;
    logic [7:0] dest_field;
    logic [7:0] first_source;
    logic [7:0] second_source;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] next_pc;
    logic halted;
    logic [3:0] flags_out;
    logic print_valid;
    logic signed [31:0] print_value;
    logic write_valid;
    logic [7:0] write_index;
    logic signed [31:0] write_value;
  } out_item_t;

  function automatic logic branch_taken(input logic [7:0] op, input logic [3:0] f);
    logic z, n, c, v;
    z = f[3];
    n = f[2];
    c = f[1];
    v = f[0];
    case (op)
      OP_BEQ: branch_taken = z;
      OP_BNE: branch_taken = !z;
      OP_BCS: branch_taken = c;
      OP_BCC: branch_taken = !c;
      OP_BMI: branch_taken = n;
      OP_BPL: branch_taken = !n;
      OP_BVS: branch_taken = v;
      OP_BVC: branch_taken = !v;
      OP_BHI: branch_taken = !z && c;
      OP_BLS: branch_taken = z && !c;
      OP_BGE: branch_taken = n == v;
      OP_BLT: branch_taken = n != v;
      OP_BGT: branch_taken = !z && (n == v);
      OP_BLE: branch_taken = z || (n != v);
      default: branch_taken = 1'b1;
    endcase
  endfunction
endpackage
`default_nettype wire

>>> rtl/scalar_vector_execute_unit.sv
// top level: scalar vector execute unit with memory based register files
//
//  channel  | direction | handshake      | payload
//  in       | input     | in_valid/stall | in_item_t
//  out      | output    | out_valid/stall| out_item_t
//  cfg      | input     | cfg_we         | pc_limit, 16 bit
//
// a scalar op that is executed steps through the states S_RDA, S_RDB, S_EXEC, S_MUL and S_DONE;
// a divide adds S_DIV (one quotient bit a cycle) and S_DIVEND, a vector op S_VRD and S_VWR (two
// lane reads, a multiply and a lane write per lane).
// after reset a clearing pass writes one entry per cycle, up to the size of the larger memory (1024
// with the default sizes), and zeroes both memories in parallel; no item is taken.
// the output register holds its item while out_stall is high; the next item
// is taken at the earliest in the cycle after the previous result has left.
`default_nettype none
module scalar_vector_execute_unit
  import sveu_pkg::*;
#(
  parameter int CONTEXTS = CONTEXTS_DEF,
  parameter int VECTOR_REGS = VECTOR_REGS_DEF,
  parameter int LANES = LANES_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire in_item_t in_item,
  output logic out_valid,
  input  wire logic out_stall,
  output out_item_t out_item,
  input  wire logic cfg_we,
  input  wire logic [15:0] cfg_data
);
  localparam int CW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
  localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int VW = (VECTOR_REGS > 1) ? $clog2(VECTOR_REGS) : 1;
  localparam int SA = CW + 8;
  localparam int VA = CW + VW + LW;
  localparam int SDEPTH = 1 << SA;
  localparam int VDEPTH = 1 << VA;
  localparam int CLRW = ((SA > VA) ? SA : VA) + 1;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RDA = 4'd2;
  localparam logic [3:0] S_RDB = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_DIV = 4'd5;
  localparam logic [3:0] S_DIVEND = 4'd6;
  localparam logic [3:0] S_VRD = 4'd7;
  localparam logic [3:0] S_VWR = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;
  localparam logic [3:0] S_MUL = 4'd10;

  logic [31:0] smem [SDEPTH];
  logic [31:0] vmem [VDEPTH];
  logic [31:0] srd, vrd;
  logic [SA-1:0] s_raddr, s_waddr;
  logic s_we;
  logic [31:0] s_wdata;
  logic [VA-1:0] v_raddr, v_waddr;
  logic v_we;
  logic [31:0] v_wdata;

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= s_wdata;
    srd <= smem[s_raddr];
  end
  always_ff @(posedge clk) begin
    if (v_we) vmem[v_waddr] <= v_wdata;
    vrd <= vmem[v_raddr];
  end

  logic [3:0] state;
  logic [CLRW-1:0] clr;
  logic [15:0] pc_limit;
  logic [31:0] pc [CONTEXTS];
  logic [3:0] flags [CONTEXTS];
  logic stopped [CONTEXTS];
  in_item_t it;
  logic [CW-1:0] cx;
  logic [31:0] a, b, pcn;
  logic [5:0] cnt;
  logic [31:0] dq, dr, dd;
  logic dneg;
  logic [LW:0] lane;
  logic [31:0] va_l, mulp;
  logic vphase;

  logic is_imm, is_vec, vec_vv, vec_vs;
  logic [3:0] kind;
  always_comb begin
    is_imm = it.op_code inside {[OP_ADDI:OP_MOVI]};
    vec_vv = it.op_code inside {[OP_VVADD:OP_VVMUL]};
    vec_vs = it.op_code inside {[OP_VSADD:OP_VSMUL]};
    is_vec = vec_vv || vec_vs || (it.op_code inside {[OP_VIADD:OP_VIMUL]});
    kind = it.op_code[3:0];
  end

  logic in_range;
  assign in_range = 32'(in_item.context_req) < 32'(CONTEXTS);
  assign in_stall = (state != S_IDLE) || out_valid;

  logic [31:0] res_add, res_sub;
  logic [3:0] f_add, f_sub;
  always_comb begin
    res_add = a + b;
    res_sub = a - b;
    f_add = ((res_add == 32'd0) ? FLAG_Z : 4'd0) | (res_add[31] ? FLAG_N : 4'd0)
          | ((res_add < a) ? FLAG_C : 4'd0)
          | (((~(a[31] ^ b[31])) & (a[31] ^ res_add[31])) ? FLAG_V : 4'd0);
    f_sub = ((res_sub == 32'd0) ? FLAG_Z : 4'd0) | (res_sub[31] ? FLAG_N : 4'd0)
          | (($signed(a) > $signed(b)) ? FLAG_C : 4'd0)
          | (((a[31] ^ b[31]) & (a[31] ^ res_sub[31])) ? FLAG_V : 4'd0);
  end

  logic [32:0] dtrial;
  always_comb dtrial = {dr[31:0], dd[31]} - {1'b0, b[31] ? (32'd0 - b) : b};

  logic s1_ok, s2_ok, d_ok;
  assign s1_ok = 32'(it.first_source) < 32'(VECTOR_REGS);
  assign s2_ok = 32'(it.second_source) < 32'(VECTOR_REGS);
  assign d_ok = 32'(it.dest_field) < 32'(VECTOR_REGS);
  logic [31:0] lane_res, vb_l;
  always_comb begin
    vb_l = vec_vv ? (s2_ok ? vrd : 32'd0) : (vec_vs ? b : {24'd0, it.second_source});
    case (kind)
      4'h1, 4'h9: lane_res = va_l + vb_l;
      4'h2, 4'hA: lane_res = va_l - vb_l;
      default: lane_res = mulp;
    endcase
  end

  always_comb begin
    s_raddr = SA'({cx, it.second_source});
    v_raddr = VA'({cx, it.first_source[VW-1:0], lane[LW-1:0]});
    if (state == S_IDLE) s_raddr = SA'({CW'(in_item.context_req), in_item.first_source});
    if ((state == S_VRD && vphase) || state == S_VWR)
      v_raddr = VA'({cx, it.second_source[VW-1:0], lane[LW-1:0]});
  end

  always_ff @(posedge clk) begin
    s_we <= 1'b0;
    v_we <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      pc_limit <= PC_LIMIT_RESET;
      out_valid <= 1'b0;
      for (int i = 0; i < CONTEXTS; i++) begin
        pc[i] <= '0;
        flags[i] <= '0;
        stopped[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) pc_limit <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          if (32'(clr) < SDEPTH) begin
            s_we <= 1'b1;
            s_waddr <= clr[SA-1:0];
            s_wdata <= '0;
          end
          if (32'(clr) < VDEPTH) begin
            v_we <= 1'b1;
            v_waddr <= clr[VA-1:0];
            v_wdata <= '0;
          end
          clr <= clr + 1'b1;
          if (32'(clr) >= SDEPTH - 1 && 32'(clr) >= VDEPTH - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !out_valid) begin
            it <= in_item;
            cx <= CW'(in_item.context_req);
            out_item <= '0;
            if (!in_range) begin
              out_valid <= 1'b1;
            end else begin
              pcn <= pc[CW'(in_item.context_req)] + 32'd4;
              state <= S_RDA;
            end
          end
        end
        S_RDA: begin
          a <= srd;
          state <= S_RDB;
        end
        S_RDB: state <= S_EXEC;
        S_EXEC: begin
          b <= is_imm ? {24'd0, it.second_source} : srd;
          out_item.next_pc <= pc[cx];
          out_item.halted <= 1'b1;
          out_item.flags_out <= flags[cx];
          if (stopped[cx]) begin
            state <= S_DONE;
          end else begin
            pc[cx] <= pcn;
            out_item.next_pc <= pcn;
            if (pcn[31] || pcn > {16'd0, pc_limit}) begin
              stopped[cx] <= 1'b1;
              state <= S_DONE;
            end else begin
              out_item.halted <= 1'b0;
              state <= S_MUL;
              if (it.op_code == OP_HALT) begin
                stopped[cx] <= 1'b1;
                out_item.halted <= 1'b1;
              end
              if ((it.op_code inside {[OP_BEQ:OP_BAL]})
                  && branch_taken(it.op_code, flags[cx])) begin
                pc[cx] <= pcn + {{22{it.second_source[7]}}, it.second_source, 2'b00};
                out_item.next_pc <= pcn + {{22{it.second_source[7]}}, it.second_source, 2'b00};
              end
              if (it.op_code == OP_PRINT) begin
                out_item.print_valid <= 1'b1;
                out_item.print_value <= srd;
              end
            end
          end
        end
        S_MUL: begin
          mulp <= a * b;
          state <= S_DONE;
          case (it.op_code)
            OP_ADD, OP_ADDI: begin
              flags[cx] <= f_add;
              out_item.flags_out <= f_add;
              out_item.write_valid <= 1'b1;
              out_item.write_index <= it.dest_field;
              out_item.write_value <= res_add;
            end
            OP_SUB, OP_SUBI: begin
              flags[cx] <= f_sub;
              out_item.flags_out <= f_sub;
              out_item.write_valid <= 1'b1;
              out_item.write_index <= it.dest_field;
              out_item.write_value <= res_sub;
            end
            OP_MUL, OP_MULI: begin
              out_item.write_valid <= 1'b1;
              out_item.write_index <= it.dest_field;
              out_item.write_value <= a * b;
            end
            OP_MOV, OP_MOVI: begin
              out_item.write_valid <= 1'b1;
              out_item.write_index <= it.dest_field;
              out_item.write_value <= b;
            end
            OP_DIV, OP_DIVI: begin
              if (b != 32'd0) begin
                dd <= a[31] ? (32'd0 - a) : a;
                dr <= '0;
                dq <= '0;
                dneg <= a[31] ^ b[31];
                cnt <= '0;
                state <= S_DIV;
              end
            end
            default: begin
              if (is_vec) begin
                lane <= '0;
                vphase <= 1'b0;
                state <= S_VRD;
              end
            end
          endcase
        end
        S_DIV: begin
          dd <= {dd[30:0], 1'b0};
          if (!dtrial[32]) begin
            dr <= dtrial[31:0];
            dq <= {dq[30:0], 1'b1};
          end else begin
            dr <= {dr[30:0], dd[31]};
            dq <= {dq[30:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == 6'd31) state <= S_DIVEND;
        end
        S_DIVEND: begin
          out_item.write_valid <= 1'b1;
          out_item.write_index <= it.dest_field;
          out_item.write_value <= dneg ? (32'd0 - dq) : dq;
          state <= S_DONE;
        end
        S_VRD: begin
          if (!vphase) begin
            vphase <= 1'b1;
          end else begin
            va_l <= s1_ok ? vrd : 32'd0;
            vphase <= 1'b0;
            state <= S_VWR;
          end
        end
        S_VWR: begin
          mulp <= (s1_ok ? va_l : 32'd0) * vb_l;
          if (vphase) begin
            v_we <= d_ok;
            v_waddr <= VA'({cx, it.dest_field[VW-1:0], lane[LW-1:0]});
            v_wdata <= lane_res;
            vphase <= 1'b0;
            lane <= lane + 1'b1;
            state <= (32'(lane) == LANES - 1) ? S_DONE : S_VRD;
          end else begin
            va_l <= s1_ok ? va_l : 32'd0;
            vphase <= 1'b1;
          end
        end
        S_DONE: begin
          if (out_item.write_valid) begin
            s_we <= 1'b1;
            s_waddr <= SA'({cx, out_item.write_index});
            s_wdata <= out_item.write_value;
          end
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/sveu_checker.sv
// checker: port level assertions of the scalar vector execute unit, with bind
`default_nettype none
module sveu_checker
  import sveu_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_item_t out_item
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item)) else $error("out item dropped");
  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result waits");
  a_pv: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.print_valid |-> out_item.print_value == 32'd0)
    else $error("print value without print");
  a_wv: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.write_valid |-> out_item.write_index == 8'd0)
    else $error("write index without write");
endmodule

bind scalar_vector_execute_unit sveu_checker u_chk (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire

>>> test/tb_scalar_vector_execute_unit.sv
// testbench: random and directed instruction streams checked against a behavioral predictor
`default_nettype none
module tb_scalar_vector_execute_unit;
  import sveu_pkg::*;

  localparam int NCTX = CONTEXTS_DEF;
  localparam int NVREG = VECTOR_REGS_DEF;
  localparam int NLANE = LANES_DEF;

  class exec_scoreboard;
    logic [15:0] limit;
    logic [31:0] sregs[NCTX][256];
    logic [31:0] vregs[NCTX][NVREG][NLANE];
    logic [31:0] pc[NCTX];
    logic [3:0] flags[NCTX];
    logic stop[NCTX];
    out_item_t pending[$];
    int errors;
    int checked;

    function void clear();
      limit = PC_LIMIT_RESET;
      foreach (sregs[c, i]) sregs[c][i] = '0;
      foreach (vregs[c, i, k]) vregs[c][i][k] = '0;
      foreach (pc[c]) begin
        pc[c] = '0;
        flags[c] = '0;
        stop[c] = 1'b0;
      end
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function logic cond_met(logic [7:0] op, logic [3:0] f);
      logic z, n, c, v;
      z = f[3];
      n = f[2];
      c = f[1];
      v = f[0];
      case (op)
        OP_BEQ: return z;
        OP_BNE: return !z;
        OP_BCS: return c;
        OP_BCC: return !c;
        OP_BMI: return n;
        OP_BPL: return !n;
        OP_BVS: return v;
        OP_BVC: return !v;
        OP_BHI: return !z && c;
        OP_BLS: return z && !c;
        OP_BGE: return n == v;
        OP_BLT: return n != v;
        OP_BGT: return !z && (n == v);
        OP_BLE: return z || (n != v);
        default: return 1'b1;
      endcase
    endfunction

    function logic [31:0] quotient(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      int c;
      logic [7:0] op, d, s1, s2;
      logic [31:0] a, b, res, npc;
      logic [31:0] va[NLANE], vb[NLANE];
      logic [3:0] kind;
      r = '0;
      c = int'(it.context_req);
      op = it.op_code;
      d = it.dest_field;
      s1 = it.first_source;
      s2 = it.second_source;
      if (!stop[c]) begin
        npc = pc[c] + 32'd4;
        pc[c] = npc;
        if (npc[31] || npc > {16'd0, limit}) begin
          stop[c] = 1'b1;
        end else begin
          a = sregs[c][s1];
          b = (op inside {[OP_ADDI:OP_MOVI]}) ? {24'd0, s2} : sregs[c][s2];
          case (op)
            OP_HALT: stop[c] = 1'b1;
            OP_ADD, OP_ADDI: begin
              res = a + b;
              flags[c] = {res == 0, res[31], res < a, (~(a ^ b) & (a ^ res)) >> 31 != 0};
              r.write_valid = 1'b1;
              r.write_value = res;
            end
            OP_SUB, OP_SUBI: begin
              res = a - b;
              flags[c] = {res == 0, res[31], (a ^ 32'h80000000) > (b ^ 32'h80000000),
                          ((a ^ b) & (a ^ res)) >> 31 != 0};
              r.write_valid = 1'b1;
              r.write_value = res;
            end
            OP_MUL, OP_MULI: begin
              r.write_valid = 1'b1;
              r.write_value = a * b;
            end
            OP_DIV, OP_DIVI: begin
              if (b != 0) begin
                r.write_valid = 1'b1;
                r.write_value = quotient(a, b);
              end
            end
            OP_MOV, OP_MOVI: begin
              r.write_valid = 1'b1;
              r.write_value = b;
            end
            OP_PRINT: begin
              r.print_valid = 1'b1;
              r.print_value = sregs[c][s2];
            end
            OP_VVADD, OP_VVSUB, OP_VVMUL, OP_VIADD, OP_VISUB, OP_VIMUL,
            OP_VSADD, OP_VSSUB, OP_VSMUL: begin
              kind = op[3:0];
              for (int k = 0; k < NLANE; k++) begin
                va[k] = (s1 < NVREG) ? vregs[c][s1][k] : '0;
                if (op[7:4] == 4'h2 && !op[3])
                  vb[k] = (s2 < NVREG) ? vregs[c][s2][k] : '0;
                else
                  vb[k] = (op[7:4] == 4'h3) ? sregs[c][s2] : {24'd0, s2};
              end
              if (d < NVREG)
                for (int k = 0; k < NLANE; k++)
                  vregs[c][d][k] = (kind == 1 || kind == 9) ? va[k] + vb[k] :
                                   (kind == 2 || kind == 4'hA) ? va[k] - vb[k] :
                                   va[k] * vb[k];
            end
            default: begin
              if ((op inside {[OP_BEQ:OP_BAL]}) && cond_met(op, flags[c]))
                pc[c] = pc[c] + ({{24{s2[7]}}, s2} << 2);
            end
          endcase
          if (r.write_valid) begin
            r.write_index = d;
            sregs[c][d] = r.write_value;
          end
        end
      end
      r.next_pc = pc[c];
      r.halted = stop[c];
      r.flags_out = flags[c];
      pending.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (got.next_pc !== e.next_pc) begin
        $error("next_pc exp %h got %h", e.next_pc, got.next_pc); errors++;
      end
      if (got.halted !== e.halted) begin
        $error("halted exp %b got %b", e.halted, got.halted); errors++;
      end
      if (got.flags_out !== e.flags_out) begin
        $error("flags_out exp %h got %h", e.flags_out, got.flags_out); errors++;
      end
      if (got.print_valid !== e.print_valid) begin
        $error("print_valid exp %b got %b", e.print_valid, got.print_valid); errors++;
      end
      if (got.print_value !== e.print_value) begin
        $error("print_value exp %h got %h", e.print_value, got.print_value); errors++;
      end
      if (got.write_valid !== e.write_valid) begin
        $error("write_valid exp %b got %b", e.write_valid, got.write_valid); errors++;
      end
      if (got.write_index !== e.write_index) begin
        $error("write_index exp %h got %h", e.write_index, got.write_index); errors++;
      end
      if (got.write_value !== e.write_value) begin
        $error("write_value exp %h got %h", e.write_value, got.write_value); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  exec_scoreboard instr_sb;
  int sent;
  logic hold_off = 1'b0;
  logic quiet_rx = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  scalar_vector_execute_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // receiver: accept and check, stall on its own pattern
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) instr_sb.check_result(out_item);
    if (rst || quiet_rx) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    instr_sb.note_item(it);
    sent++;
  endtask

  task automatic idle_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    instr_sb.limit = v;
  endtask

  task automatic drain();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (instr_sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] c, logic [7:0] op, logic [7:0] d,
                                  logic [7:0] s1, logic [7:0] s2);
    in_item_t it;
    it.context_req = c;
    it.op_code = op;
    it.dest_field = d;
    it.first_source = s1;
    it.second_source = s2;
    return it;
  endfunction

  function automatic logic [7:0] pick_op();
    logic [7:0] ops[33] = '{OP_HALT, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOV, OP_PRINT,
      OP_ADDI, OP_SUBI, OP_MULI, OP_DIVI, OP_MOVI, OP_BEQ, OP_BNE, OP_BCS, OP_BCC,
      OP_BMI, OP_BPL, OP_BVS, OP_BVC, OP_BHI, OP_BLS, OP_BGE, OP_BLT, OP_BGT, OP_BLE,
      OP_BAL, OP_VVADD, OP_VVSUB, OP_VVMUL, OP_VIADD, OP_VISUB, OP_VSADD};
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return OP_HALT;
    if (r < 8) return 8'($urandom_range(0, 255));
    if (r < 12) return (r < 10) ? OP_VSSUB : OP_VSMUL;
    if (r < 14) return (r < 13) ? OP_VIMUL : OP_VISUB;
    return ops[$urandom_range(1, 32)];
  endfunction

  task automatic random_phase(int n);
    in_item_t it;
    logic [7:0] op;
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        op = pick_op();
        it = mk(2'($urandom_range(0, 3)), op,
                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 40)),
                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 40)),
                ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 40)));
        // branches mostly short so programs keep running
        if ((op inside {[OP_BEQ:OP_BAL]}) && $urandom_range(0, 3) != 0)
          it.second_source = $urandom_range(0, 1) ? 8'hFF : 8'h01;
        send_item(it);
        burst--;
        n--;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 15));
    end
  endtask

  initial begin
    #20000000;
    $display("tb_scalar_vector_execute_unit: FAIL");
    $finish;
  end

  initial begin
    instr_sb = new();
    instr_sb.clear();
    sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_limit(16'd1024);
    // directed: operand extremes, flags, divide corners, every op family
    send_item(mk(2'd0, OP_MOVI, 8'd1, 8'd0, 8'hFF));
    send_item(mk(2'd0, OP_SUBI, 8'd2, 8'd0, 8'd1));
    send_item(mk(2'd0, OP_ADDI, 8'd3, 8'd2, 8'd1));
    send_item(mk(2'd0, OP_BEQ, 8'd0, 8'd0, 8'h01));
    send_item(mk(2'd0, OP_SUB, 8'd4, 8'd0, 8'd2));
    send_item(mk(2'd0, OP_DIV, 8'd5, 8'd1, 8'd0));
    send_item(mk(2'd0, OP_DIV, 8'd6, 8'd2, 8'd1));
    send_item(mk(2'd0, OP_MULI, 8'd7, 8'd2, 8'h80));
    send_item(mk(2'd1, OP_MOVI, 8'd10, 8'd0, 8'h80));
    send_item(mk(2'd1, OP_MUL, 8'd10, 8'd10, 8'd10));
    send_item(mk(2'd1, OP_MUL, 8'd10, 8'd10, 8'd10));
    send_item(mk(2'd1, OP_MULI, 8'd10, 8'd10, 8'h80));
    send_item(mk(2'd1, OP_SUBI, 8'd11, 8'd0, 8'd1));
    send_item(mk(2'd1, OP_DIV, 8'd12, 8'd10, 8'd11));
    send_item(mk(2'd1, OP_ADD, 8'd13, 8'd10, 8'd10));
    send_item(mk(2'd1, OP_PRINT, 8'd0, 8'd0, 8'd13));
    send_item(mk(2'd2, OP_VIADD, 8'd1, 8'd0, 8'hFF));
    send_item(mk(2'd2, OP_VVMUL, 8'd31, 8'd1, 8'd1));
    send_item(mk(2'd2, OP_VSADD, 8'hFF, 8'hFF, 8'hFF));
    send_item(mk(2'd2, OP_BAL, 8'hFF, 8'hFF, 8'h80));
    send_item(mk(2'd2, OP_ADD, 8'd0, 8'd0, 8'd0));
    send_item(mk(2'd3, OP_HALT, 8'd0, 8'd0, 8'd0));
    send_item(mk(2'd3, OP_ADD, 8'd0, 8'd0, 8'd0));
    drain();
    write_limit(16'hFFFF);
    random_phase(300);
    // long receiver hold-off so the unit backs up into its input
    fork
      begin
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      random_phase(20);
    join
    drain();
    write_limit(16'd0);
    random_phase(30);
    drain();
    write_limit(16'd200);
    quiet_rx <= 1'b1;
    random_phase(150);
    quiet_rx <= 1'b0;
    drain();
    write_limit(16'd600);
    random_phase(430);
    drain();
    $display("run covered %0d instructions, %0d results checked over 5 pc limits",
             sent, instr_sb.checked);
    if (instr_sb.errors == 0 && instr_sb.pending.size() == 0) begin
      $display("tb_scalar_vector_execute_unit: PASS");
    end else begin
      $display("tb_scalar_vector_execute_unit: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
